FILE: rtl/leveled_irq_controller_assert.svh
// ----------------------------------------------------------------------------
// Leveled IRQ controller assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef LEVELED_IRQ_CONTROLLER_ASSERT_SVH
`define LEVELED_IRQ_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LIC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LIC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lic_pkg.sv
// ----------------------------------------------------------------------------
// Leveled IRQ controller package
// Shared constants, word types and the level select function.
// ----------------------------------------------------------------------------
`default_nettype none

package lic_pkg;

   localparam int LineCount = 4;
   localparam int LineW     = 2;
   localparam int LevelW    = 3;
   localparam int OpW       = 2;
   localparam int OffsetW   = 5;
   localparam int DataW     = 8;
   localparam int ReqDataW  = 16;
   localparam int RspDataW  = 16;

   localparam logic [OpW-1:0] OP_WRITE    = 2'd0;
   localparam logic [OpW-1:0] OP_VBLANK   = 2'd1;
   localparam logic [OpW-1:0] OP_SCANLINE = 2'd2;

   localparam logic [LineW-1:0] LINE_VBLANK   = 2'd0;
   localparam logic [LineW-1:0] LINE_SCANLINE = 2'd1;

   typedef logic [LineCount-1:0][LevelW-1:0] level_array_type;

   typedef struct packed {
      logic [OpW-1:0]     operation;
      logic [OffsetW-1:0] offset;
      logic [DataW-1:0]   data;
   } req_type;

   typedef struct packed {
      logic [LineCount-1:0] enabled_mask;
      logic [LineCount-1:0] pending_mask;
      logic [LevelW-1:0]    active_level;
   } rsp_type;

   function automatic logic [LevelW-1:0] highest_level(
      input level_array_type      levels,
      input logic [LineCount-1:0] pending
   );
      logic [LevelW-1:0] best;
      best = '0;
      for (int n = 0; n < LineCount; n++) begin
         if (pending[n] && (levels[n] > best)) begin
            best = levels[n];
         end
      end
      return best;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/lic_in_stage.sv
// ----------------------------------------------------------------------------
// Leveled IRQ controller input stage
// Holds one accepted request word until the core commits it.
// ----------------------------------------------------------------------------
`default_nettype none

module lic_in_stage
   import lic_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire req_type req_item,
   input  wire logic    advance,
   output logic         item_valid,
   output req_type      item
);

   logic    valid_ff, valid_in;
   req_type item_ff;
   logic    accept;

   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

FILE: rtl/lic_core.sv
// ----------------------------------------------------------------------------
// Leveled IRQ controller core
// Line level, enable and pending state; next state and result per word.
// ----------------------------------------------------------------------------
`default_nettype none

module lic_core
   import lic_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    commit,
   input  wire req_type item,
   output rsp_type      result
);

   level_array_type      level_ff, level_in;
   logic [LineCount-1:0] enabled_ff, enabled_in;
   logic [LineCount-1:0] pending_ff, pending_in;

   logic [LineW-1:0]  line;
   logic [LevelW-1:0] new_level;
   logic              is_level_reg;
   logic              is_ack_reg;

   assign line         = item.offset[LineW-1:0];
   assign new_level    = item.data[LevelW-1:0];
   assign is_level_reg = (item.offset[OffsetW-1:LineW] == '0);
   assign is_ack_reg   = (item.offset[OffsetW-1:LineW+1] == '0) && item.offset[LineW];

   always_comb begin
      level_in   = level_ff;
      enabled_in = enabled_ff;
      pending_in = pending_ff;
      case (item.operation)
         OP_WRITE: begin
            if (is_level_reg) begin
               level_in[line] = new_level;
               if (new_level != '0) begin
                  enabled_in[line] = 1'b1;
               end else begin
                  enabled_in[line] = 1'b0;
                  pending_in[line] = 1'b0;
               end
            end else if (is_ack_reg) begin
               pending_in[line] = 1'b0;
            end
         end
         OP_VBLANK: begin
            if (enabled_ff[LINE_VBLANK]) begin
               pending_in[LINE_VBLANK] = 1'b1;
            end
         end
         OP_SCANLINE: begin
            if (enabled_ff[LINE_SCANLINE]) begin
               pending_in[LINE_SCANLINE] = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= '0;
         enabled_ff <= '0;
         pending_ff <= '0;
      end else if (commit) begin
         level_ff   <= level_in;
         enabled_ff <= enabled_in;
         pending_ff <= pending_in;
      end
   end

   assign result.active_level = highest_level(level_in, pending_in);
   assign result.pending_mask = pending_in;
   assign result.enabled_mask = enabled_in;

endmodule

`default_nettype wire

FILE: rtl/lic_out_stage.sv
// ----------------------------------------------------------------------------
// Leveled IRQ controller output stage
// Result register; holds the word while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module lic_out_stage
   import lic_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type result,
   output logic         free,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output rsp_type      rsp_item
);

   logic    valid_ff, valid_in;
   rsp_type item_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

endmodule

`default_nettype wire

FILE: rtl/leveled_irq_controller.sv
// ----------------------------------------------------------------------------
// Leveled IRQ controller
// Four-line priority-level interrupt controller, one word per cycle when not stalled.
// ----------------------------------------------------------------------------
// Request channel (req_): each word is a register write, a vblank event or a
// scanline event, selected by req_tuser. Writes to offsets 0-3 set a line
// level (zero disables the line), offsets 4-7 acknowledge a line.
// Response channel (rsp_): one word per request, carrying the highest
// pending level and the pending and enabled masks after that request.
// A request passes the input register, then the result register.
// Throughput: one word per cycle while the receiver does not stall, set by
// the state update between the two registers.
// Reset clears all levels, enables and pending bits and both registers;
// req_tready is high right after reset.
// When the receiver stalls, the response holds in the result register, one
// more request waits in the input register, then req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module leveled_irq_controller
   import lic_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [ReqDataW-1:0] req_tdata,  // [4:0] offset, [12:5] data
   input  wire logic [OpW-1:0]      req_tuser,  // [1:0] operation
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RspDataW-1:0]      rsp_tdata   // [2:0] active_level, [6:3] pending_mask,
                                                // [10:7] enabled_mask
);

   req_type req_item;
   req_type item;
   logic    item_valid;
   logic    advance;
   logic    out_free;
   rsp_type result;
   rsp_type rsp_item;

   assign req_item.operation = req_tuser;
   assign req_item.offset    = req_tdata[OffsetW-1:0];
   assign req_item.data      = req_tdata[OffsetW+DataW-1:OffsetW];

   assign advance = item_valid && out_free;

   lic_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   lic_core u_core (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .item   (item),
      .result (result)
   );

   lic_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {{(RspDataW - $bits(rsp_type)){1'b0}}, rsp_item};

endmodule

`default_nettype wire

FILE: rtl/lic_checker.sv
// ----------------------------------------------------------------------------
// Leveled IRQ controller port checker
// Port-level properties of the controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "leveled_irq_controller_assert.svh"

module lic_checker
   import lic_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_tready,
   input wire logic                rsp_tvalid,
   input wire logic                rsp_tready,
   input wire logic [RspDataW-1:0] rsp_tdata
);

   rsp_type rsp_word;
   logic    rsp_stall;
   logic    level_up;
   logic    any_pending;
   logic    stray_pending;

   assign rsp_word      = rsp_tdata[$bits(rsp_type)-1:0];
   assign rsp_stall     = rsp_tvalid && !rsp_tready;
   assign level_up      = rsp_tvalid && (rsp_word.active_level != '0);
   assign any_pending   = (rsp_word.pending_mask != '0);
   assign stray_pending = ((rsp_word.pending_mask & ~rsp_word.enabled_mask) != '0);

   `LIC_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "stalled word moved")
   `LIC_ASSERT_NOW(a_level_needs_pending, level_up, any_pending, "level with nothing pending")
   `LIC_ASSERT_NOW(a_pending_enabled, rsp_tvalid, !stray_pending, "pending bit on a disabled line")
   `LIC_ASSERT_NOW(a_reset_idle, $past(reset), !rsp_tvalid && req_tready, "not idle after reset")

endmodule

bind leveled_irq_controller lic_checker u_lic_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
